// File: hw/rtl/tbwp_pkg.sv
// Shared types and constants for the tiled background/window pixel renderer.
`default_nettype none

package tbwp_pkg;

    // Video memory geometry (byte offsets from the CPU address 0x8000)
    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);

    localparam logic [15:0] VRAM_BASE = 16'h8000;

    localparam logic [VRAM_AW-1:0] MAP_LOW_OFS       = VRAM_AW'(16'h9800 - VRAM_BASE);
    localparam logic [VRAM_AW-1:0] MAP_HIGH_OFS      = VRAM_AW'(16'h9C00 - VRAM_BASE);
    localparam logic [VRAM_AW-1:0] DATA_UNSIGNED_OFS = VRAM_AW'(16'h8000 - VRAM_BASE);
    localparam logic [VRAM_AW-1:0] DATA_SIGNED_OFS   = VRAM_AW'(16'h8800 - VRAM_BASE);

    // Window column register holds the column plus this offset
    localparam logic [7:0] WIN_X_OFS = 8'd7;

    // display control bit positions
    localparam int LCDC_BG_ON    = 0;
    localparam int LCDC_BG_MAP   = 3;
    localparam int LCDC_TILE_SEL = 4;
    localparam int LCDC_WIN_ON   = 5;
    localparam int LCDC_WIN_MAP  = 6;

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_CTRL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_OFS_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_OFS_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_PALETTE    = 3'd5;

    // Item kinds carried on tuser
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_PIXEL = 2'd1,
        MODE_EOL   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] disp_ctrl;
        logic [7:0] bg_ofs_y;
        logic [7:0] bg_ofs_x;
        logic [7:0] window_top;
        logic [7:0] window_left_raw;
        logic [7:0] bg_palette;
    } t_cfg;

    typedef enum logic {
        STEP_MAP   = 1'b0,
        STEP_PLANE = 1'b1
    } t_step;

    // Request into the address unit
    typedef struct packed {
        t_step      step;
        logic [7:0] column;
        logic [7:0] line;
        logic [7:0] tnum;
        logic [2:0] yfine;
        logic       plane;
    } t_agen_req;

    // Fine (within-tile) coordinates of the map fetch
    typedef struct packed {
        logic [2:0] x;
        logic [2:0] y;
    } t_fine;

    function automatic logic [7:0] shade_to_gray(input logic [1:0] shade);
        logic [7:0] g;
        case (shade)
            2'd0:    g = 8'd255;
            2'd1:    g = 8'd170;
            2'd2:    g = 8'd85;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tbwp_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module tbwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// File: hw/rtl/tbwp_agen.sv
// Shared video memory address unit: tile map address or tile plane address.
`default_nettype none

module tbwp_agen (
    input  tbwp_pkg::t_cfg                   i_cfg,
    input  tbwp_pkg::t_agen_req              i_req,
    output logic [tbwp_pkg::VRAM_AW-1:0]     o_addr,
    output tbwp_pkg::t_fine                  o_fine
);
    import tbwp_pkg::*;

    logic [7:0]         win_col;
    logic               use_win;
    logic [7:0]         xp;
    logic [7:0]         yp;
    logic               map_hi;
    logic [VRAM_AW-1:0] map_addr;
    logic [7:0]         tile_eff;
    logic [VRAM_AW-1:0] data_base;
    logic [VRAM_AW-1:0] tile_addr;

    // window vs scrolled background
    always_comb begin
        win_col = i_cfg.window_left_raw - WIN_X_OFS;
        use_win = i_cfg.disp_ctrl[LCDC_WIN_ON] && (i_cfg.window_top <= i_req.line)
                  && (i_req.column >= win_col);
        if (use_win) begin
            yp     = i_req.line - i_cfg.window_top;
            xp     = i_req.column - win_col;
            map_hi = i_cfg.disp_ctrl[LCDC_WIN_MAP];
        end else begin
            yp     = i_req.line + i_cfg.bg_ofs_y;
            xp     = i_req.column + i_cfg.bg_ofs_x;
            map_hi = i_cfg.disp_ctrl[LCDC_BG_MAP];
        end
        map_addr = (map_hi ? MAP_HIGH_OFS : MAP_LOW_OFS) + VRAM_AW'({yp[7:3], xp[7:3]});
    end

    // tile data: unsigned from 0x8000, or signed around 0x9000 (0x8800 + (n+128)*16)
    always_comb begin
        if (i_cfg.disp_ctrl[LCDC_TILE_SEL]) begin
            tile_eff  = i_req.tnum;
            data_base = DATA_UNSIGNED_OFS;
        end else begin
            tile_eff  = i_req.tnum ^ 8'h80;
            data_base = DATA_SIGNED_OFS;
        end
        tile_addr = data_base + VRAM_AW'({tile_eff, i_req.yfine, i_req.plane});
    end

    always_comb begin
        unique case (i_req.step)
            STEP_MAP:   o_addr = map_addr;
            STEP_PLANE: o_addr = tile_addr;
            default:    o_addr = map_addr;
        endcase
        o_fine.x = xp[2:0];
        o_fine.y = yp[2:0];
    end

endmodule

`default_nettype wire

// File: hw/rtl/tile_background_window_pixel.sv
// Top level of the tiled background/window pixel renderer.
// Pixel request: three reads of the single-port video memory (tile number, low plane,
//   high plane); the result is registered after the tile, low and high states, and a new
//   pixel is taken in the high state when the output is free, the third read overlapping
//   the next map read. Memory write and end-of-line items give no result.
// Reset clears the sequencer, output valid, line counter and config registers;
//   video memory contents are not cleared and must be loaded before rendering.
`default_nettype none

module tile_background_window_pixel #(
    parameter int LINE_WIDTH        = 160,
    parameter int LINES_PER_FRAME   = 154,
    parameter int LAST_VISIBLE_LINE = 143
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [tbwp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [7:0]                         i_cfg_data,

    // input items
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [31:0]                        s_axis_tdata,  // mem_addr, mem_data, column
    input  wire logic [1:0]                         s_axis_tuser,  // mode

    // rendered pixels
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [23:0]                             m_axis_tdata   // out_column, out_line, gray
);
    import tbwp_pkg::*;

    // one-hot sequencer; each state names the read whose data the RAM presents
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TILE = 4'b0010,   // tile number on the RAM output
        S_LOW  = 4'b0100,   // low plane byte on the RAM output
        S_HIGH = 4'b1000    // high plane byte on the RAM output
    } t_state;

    t_state             r_state, n_state;
    t_cfg               r_cfg;
    logic [7:0]         r_line;

    // pixel context captured at the input transfer, then tile number and low plane byte
    logic [7:0]         r_col;
    logic [7:0]         r_pline;
    logic [2:0]         r_xfine;
    logic [2:0]         r_yfine;
    logic [7:0]         r_tnum;
    logic [7:0]         r_lo;

    logic               r_ovalid;
    logic [23:0]        r_odata;

    logic               accept;
    logic [VRAM_AW-1:0] in_addr;
    logic [7:0]         in_data;
    logic [7:0]         in_col;
    logic               pix_ok;
    logic               pix_go;
    logic               wr_go;
    logic               eol_go;
    logic               out_free;

    t_agen_req          agen_req;
    logic [VRAM_AW-1:0] agen_addr;
    t_fine              agen_fine;

    logic               ram_re;
    logic [VRAM_AW-1:0] ram_addr;
    logic [7:0]         ram_q;

    logic [2:0]         pick;
    logic [1:0]         color;
    logic [1:0]         shade;
    logic [7:0]         gray;

    assign in_addr = s_axis_tdata[12:0];
    assign in_data = s_axis_tdata[20:13];
    assign in_col  = s_axis_tdata[28:21];

    assign out_free      = !r_ovalid || m_axis_tready;
    // ready while idle, or on the last read when the output register can take the pixel
    assign s_axis_tready = (r_state == S_IDLE) || ((r_state == S_HIGH) && out_free);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pix_ok = r_cfg.disp_ctrl[LCDC_BG_ON]
                    && (r_line <= 8'(LAST_VISIBLE_LINE))
                    && ({1'b0, in_col} < 9'(LINE_WIDTH));
    assign pix_go = accept && (s_axis_tuser == MODE_PIXEL) && pix_ok;
    assign wr_go  = accept && (s_axis_tuser == MODE_WRITE);
    assign eol_go = accept && (s_axis_tuser == MODE_EOL);

    // shared address unit: map read in the transfer cycle, plane reads after
    always_comb begin
        agen_req.step   = ((r_state == S_IDLE) || (r_state == S_HIGH)) ? STEP_MAP : STEP_PLANE;
        agen_req.column = in_col;
        agen_req.line   = r_line;
        agen_req.tnum   = (r_state == S_TILE) ? ram_q : r_tnum;
        agen_req.yfine  = r_yfine;
        agen_req.plane  = (r_state == S_LOW);
    end

    tbwp_agen u_agen (
        .i_cfg  (r_cfg),
        .i_req  (agen_req),
        .o_addr (agen_addr),
        .o_fine (agen_fine)
    );

    assign ram_re   = pix_go || (r_state == S_TILE) || (r_state == S_LOW);
    assign ram_addr = wr_go ? in_addr : agen_addr;

    tbwp_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_BYTES)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (wr_go),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (in_data),
        .o_rdata (ram_q)
    );

    // colour from the two planes (leftmost pixel in bit 7), then palette
    always_comb begin
        pick  = ~r_xfine;
        color = {ram_q[pick], r_lo[pick]};
        shade = r_cfg.bg_palette[{color, 1'b0} +: 2];
        gray  = shade_to_gray(shade);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pix_go) begin
                    n_state = S_TILE;
                end
            end
            S_TILE: n_state = S_LOW;
            S_LOW:  n_state = S_HIGH;
            S_HIGH: begin
                if (out_free) begin
                    n_state = pix_go ? S_TILE : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config registers, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISP_CTRL:   r_cfg.disp_ctrl       <= i_cfg_data;
                CFG_BG_OFS_Y:    r_cfg.bg_ofs_y        <= i_cfg_data;
                CFG_BG_OFS_X:    r_cfg.bg_ofs_x        <= i_cfg_data;
                CFG_WINDOW_TOP:  r_cfg.window_top      <= i_cfg_data;
                CFG_WINDOW_LEFT: r_cfg.window_left_raw <= i_cfg_data;
                CFG_BG_PALETTE:  r_cfg.bg_palette      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line counter wraps at the frame length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (eol_go) begin
            if (r_line == 8'(LINES_PER_FRAME - 1)) begin
                r_line <= '0;
            end else begin
                r_line <= r_line + 8'd1;
            end
        end
    end

    // pixel payload
    always_ff @(posedge i_clk) begin
        if (pix_go) begin
            r_col   <= in_col;
            r_pline <= r_line;
            r_xfine <= agen_fine.x;
            r_yfine <= agen_fine.y;
        end
        if (r_state == S_TILE) begin
            r_tnum <= ram_q;
        end
        if (r_state == S_LOW) begin
            r_lo <= ram_q;
        end
        if ((r_state == S_HIGH) && out_free) begin
            r_odata <= {gray, r_pline, r_col};
        end
    end

    // output register; the RAM holds the high plane byte while this is full and not taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_HIGH) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

`default_nettype wire
